### hw/rtl/ring_buffer_delimited_frame_pop_top_assert.svh
// Assertion macros for the delimited-frame ring buffer.
// No dependencies; included by the top level.
`ifndef RING_BUFFER_DELIMITED_FRAME_POP_TOP_ASSERT_SVH
`define RING_BUFFER_DELIMITED_FRAME_POP_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// condition must hold at every edge out of reset
`define RBDF_ASSERT(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error("rbdf assertion failed");
// antecedent implies consequent in the same cycle
`define RBDF_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("rbdf assertion failed");
// antecedent implies consequent in the next cycle
`define RBDF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("rbdf assertion failed");
`else
`define RBDF_ASSERT(label, clk, rst_n, cond)
`define RBDF_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define RBDF_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

### hw/rtl/rbdf_pkg.sv
// Shared widths, command codes and result type for the delimited-frame ring buffer.
// No dependencies.
package rbdf_pkg;
	localparam int DEPTH_DEF = 64;
	localparam int BYTE_W    = 8;
	localparam int FILL_W    = 6;

	// command codes
	localparam logic CMD_PUSH    = 1'b0;
	localparam logic CMD_CONSUME = 1'b1;

	typedef struct packed {
		logic [BYTE_W-1:0] out_byte;
		logic              byte_valid;
		logic              last;
		logic              not_found;
		logic              overflow;
		logic [FILL_W-1:0] fill_level;
		logic              empty_res;
	} res_t;
endpackage

### hw/rtl/rbdf_if.sv
// Request and result channel interfaces (valid/ready) for the ring buffer.
// Depends on rbdf_pkg.
interface rbdf_req_if
	import rbdf_pkg::*;
	;
	logic              valid;
	logic              ready;
	logic              cmd;
	logic [BYTE_W-1:0] push_byte;
	logic [BYTE_W-1:0] delimiter;

	modport source (output valid, cmd, push_byte, delimiter, input ready);
	modport sink   (input valid, cmd, push_byte, delimiter, output ready);
endinterface

interface rbdf_res_if
	import rbdf_pkg::*;
	;
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] out_byte;
	logic              byte_valid;
	logic              last;
	logic              not_found;
	logic              overflow;
	logic [FILL_W-1:0] fill_level;
	logic              empty_res;

	modport source (output valid, out_byte, byte_valid, last, not_found, overflow,
		fill_level, empty_res, input ready);
	modport sink   (input valid, out_byte, byte_valid, last, not_found, overflow,
		fill_level, empty_res, output ready);
endinterface

### hw/rtl/ring_buffer_delimited_frame_pop_top.sv
// Delimited-frame byte ring buffer: one synchronous byte memory plus pointers and a sequencer.
// Depends on rbdf_pkg, rbdf_if.sv and ring_buffer_delimited_frame_pop_top_assert.svh.

// A push request stores one byte (or is dropped with overflow once DEPTH-1 bytes are held)
// and presents one result, loaded from the result state into the output register. A consume
// request scans the held bytes from the read pointer through the single memory read port,
// one byte per cycle, then emits the frame up to and including the delimiter one byte at a
// time (issue read, register data, load the output register once it is free), all bytes
// marked with the fill level after removal; with no delimiter held it yields one not-found
// result. One request is worked at a time and the next is taken once the last result has
// been loaded into the output register. The memory needs no clearing pass: only written
// bytes are ever read.
`include "ring_buffer_delimited_frame_pop_top_assert.svh"

module ring_buffer_delimited_frame_pop_top
	import rbdf_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	rbdf_req_if.sink      cmd_ch,
	rbdf_res_if.source    res_ch
);
	localparam int PW = $clog2(DEPTH);

	// sequencer codes
	localparam logic [2:0] S_IDLE      = 3'd0;
	localparam logic [2:0] S_RES       = 3'd1;
	localparam logic [2:0] S_SCAN      = 3'd2;
	localparam logic [2:0] S_EMIT_RD   = 3'd3;
	localparam logic [2:0] S_EMIT_WAIT = 3'd4;

	function automatic logic [PW-1:0] wrap_next(input logic [PW-1:0] p);
		return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	logic [2:0]        state_q;
	logic [PW-1:0]     wp_q, rp_q, sp_q, ep_q, end_q;
	logic [BYTE_W-1:0] delim_q;
	logic              ovf_q, nf_q;
	logic [PW-1:0]     addr_s1;
	logic              v_s1;

	// byte memory with registered read
	logic [BYTE_W-1:0] byte_store_q [DEPTH];
	logic [BYTE_W-1:0] rd_data_q;
	logic              mem_we, mem_re;
	logic [PW-1:0]     mem_ra;

	logic              out_valid_q;
	res_t              res_q, res_d;
	logic              res_ld, out_free;
	logic              req_acc;

	logic [PW:0]       held;
	logic              full, hit;

	// fill level from the current pointers
	always_comb begin
		if (wp_q >= rp_q) begin
			held = {1'b0, wp_q} - {1'b0, rp_q};
		end else begin
			held = (PW+1)'(DEPTH) - {1'b0, rp_q} + {1'b0, wp_q};
		end
	end
	assign full = (held >= (PW+1)'(DEPTH - 1));
	assign hit  = v_s1 && (rd_data_q == delim_q);

	assign cmd_ch.ready = (state_q == S_IDLE);
	assign req_acc      = cmd_ch.valid && cmd_ch.ready;
	assign out_free     = !out_valid_q || res_ch.ready;

	// memory port controls; writes only in idle, reads only while scanning or emitting
	assign mem_we = req_acc && (cmd_ch.cmd == CMD_PUSH) && !full;
	always_comb begin
		mem_re = 1'b0;
		mem_ra = sp_q;
		if (state_q == S_SCAN && !hit && sp_q != wp_q) begin
			mem_re = 1'b1;
		end else if (state_q == S_EMIT_RD) begin
			mem_re = 1'b1;
			mem_ra = ep_q;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			byte_store_q[wp_q] <= cmd_ch.push_byte;
		end
		if (mem_re) begin
			rd_data_q <= byte_store_q[mem_ra];
		end
	end

	// result selection
	always_comb begin
		res_ld           = 1'b0;
		res_d            = '0;
		res_d.fill_level = FILL_W'(held);
		res_d.empty_res  = (wp_q == rp_q);
		if (out_free) begin
			if (state_q == S_RES) begin
				res_ld          = 1'b1;
				res_d.last      = 1'b1;
				res_d.overflow  = ovf_q;
				res_d.not_found = nf_q;
			end else if (state_q == S_EMIT_WAIT) begin
				res_ld           = 1'b1;
				res_d.out_byte   = rd_data_q;
				res_d.byte_valid = 1'b1;
				res_d.last       = (ep_q == end_q);
			end
		end
	end

	// sequencer and pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			wp_q    <= '0;
			rp_q    <= '0;
			v_s1    <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (req_acc) begin
						if (cmd_ch.cmd == CMD_PUSH) begin
							if (!full) begin
								wp_q <= wrap_next(wp_q);
							end
							state_q <= S_RES;
						end else begin
							v_s1    <= 1'b0;
							state_q <= S_SCAN;
						end
					end
				end
				S_RES: begin
					if (res_ld) begin
						state_q <= S_IDLE;
					end
				end
				S_SCAN: begin
					if (hit) begin
						rp_q    <= wrap_next(addr_s1);
						v_s1    <= 1'b0;
						state_q <= S_EMIT_RD;
					end else if (sp_q == wp_q && !v_s1) begin
						state_q <= S_RES;
					end else begin
						v_s1 <= mem_re;
					end
				end
				S_EMIT_RD: begin
					state_q <= S_EMIT_WAIT;
				end
				S_EMIT_WAIT: begin
					if (res_ld) begin
						state_q <= (ep_q == end_q) ? S_IDLE : S_EMIT_RD;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// request payload, scan and emit pointers
	always_ff @(posedge clk) begin
		if (req_acc) begin
			delim_q <= cmd_ch.delimiter;
			sp_q    <= rp_q;
			ovf_q   <= (cmd_ch.cmd == CMD_PUSH) && full;
			nf_q    <= (cmd_ch.cmd == CMD_CONSUME);
		end
		if (state_q == S_SCAN) begin
			if (hit) begin
				end_q <= addr_s1;
				ep_q  <= rp_q;
			end else if (mem_re) begin
				addr_s1 <= sp_q;
				sp_q    <= wrap_next(sp_q);
			end
		end
		if (state_q == S_EMIT_WAIT && res_ld) begin
			ep_q <= wrap_next(ep_q);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= res_ld;
		end
	end
	always_ff @(posedge clk) begin
		if (res_ld) begin
			res_q <= res_d;
		end
	end

	assign res_ch.valid      = out_valid_q;
	assign res_ch.out_byte   = res_q.out_byte;
	assign res_ch.byte_valid = res_q.byte_valid;
	assign res_ch.last       = res_q.last;
	assign res_ch.not_found  = res_q.not_found;
	assign res_ch.overflow   = res_q.overflow;
	assign res_ch.fill_level = res_q.fill_level;
	assign res_ch.empty_res  = res_q.empty_res;

	// checks
	`RBDF_ASSERT(a_fill_bound, clk, arst_n, held <= (PW+1)'(DEPTH - 1))
	`RBDF_ASSERT_IMPL(a_no_rw_overlap, clk, arst_n, mem_we, !mem_re && state_q == S_IDLE)
	`RBDF_ASSERT_NEXT(a_frame_ends_on_delim, clk, arst_n,
		res_ld && res_d.byte_valid && res_d.last, res_q.out_byte == delim_q)
	`RBDF_ASSERT_IMPL(a_emit_only_after_rd, clk, arst_n, state_q == S_EMIT_WAIT,
		$past(state_q) == S_EMIT_RD || $past(state_q) == S_EMIT_WAIT)
endmodule

### sim/ring_buffer_delimited_frame_pop_top_tb.sv
`timescale 1ns / 100ps
// Testbench for the delimited-frame byte ring buffer: directed and random push and consume
// requests against a behavioral copy of the ring, results checked field by field.
// Depends on rbdf_pkg, rbdf_if.sv and ring_buffer_delimited_frame_pop_top.sv.
module ring_buffer_delimited_frame_pop_top_tb;
	import rbdf_pkg::*;

	localparam logic [BYTE_W-1:0] SENTINEL   = 8'hC3;
	localparam int                HOLD_AT    = 60;
	localparam int                HOLD_LEN   = 400;
	localparam int                TAIL_WAIT  = 300;
	localparam int                TIMEOUT_NS = 4_000_000;

	typedef struct {
		logic              cmd;
		logic [BYTE_W-1:0] push_byte;
		logic [BYTE_W-1:0] delimiter;
		bit                drain_first;
	} ring_req_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	rbdf_req_if cmd_ch ();
	rbdf_res_if res_ch ();

	ring_buffer_delimited_frame_pop_top i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_ch(cmd_ch),
		.res_ch(res_ch)
	);

	always #2 clk = ~clk;

	// shadow copy of the ring
	logic [BYTE_W-1:0] ring_mem [64];
	logic [FILL_W-1:0] wr_ptr = '0;
	logic [FILL_W-1:0] rd_ptr = '0;

	ring_req_t pending_reqs [$];
	res_t      expected_res [$];

	int unsigned n_fail = 0;
	int unsigned n_accepted = 0;
	int unsigned n_checked = 0;
	int unsigned n_frames = 0;
	int unsigned n_not_found = 0;
	int unsigned n_overflow = 0;
	int unsigned max_frame = 0;

	logic req_fire = 1'b0;
	logic res_fire = 1'b0;

	task automatic note_failure(input string msg);
		$display("[%0t] mismatch: %s", $realtime, msg);
		n_fail++;
	endtask

	// work out the results of one accepted request and update the shadow ring
	function automatic void predict_request(logic cmd, logic [BYTE_W-1:0] pb,
		logic [BYTE_W-1:0] dl);
		res_t              r;
		logic [FILL_W-1:0] p;
		logic [BYTE_W-1:0] frame [$];
		bit                hit;
		r = '0;
		r.last = 1'b1;
		if (cmd == CMD_PUSH) begin
			if (FILL_W'(wr_ptr - rd_ptr) == {FILL_W{1'b1}}) begin
				r.overflow = 1'b1;
				n_overflow++;
			end else begin
				ring_mem[wr_ptr] = pb;
				wr_ptr = wr_ptr + 1'b1;
			end
			r.fill_level = wr_ptr - rd_ptr;
			r.empty_res = (wr_ptr == rd_ptr);
			expected_res.push_back(r);
			return;
		end
		// scan held bytes for the delimiter
		p = rd_ptr;
		hit = 1'b0;
		while (p != wr_ptr && !hit) begin
			frame.push_back(ring_mem[p]);
			hit = (ring_mem[p] == dl);
			p = p + 1'b1;
		end
		if (!hit) begin
			r.not_found = 1'b1;
			r.fill_level = wr_ptr - rd_ptr;
			r.empty_res = (wr_ptr == rd_ptr);
			expected_res.push_back(r);
			n_not_found++;
			return;
		end
		rd_ptr = p;
		n_frames++;
		if (frame.size() > max_frame)
			max_frame = frame.size();
		foreach (frame[i]) begin
			r.out_byte = frame[i];
			r.byte_valid = 1'b1;
			r.last = (i == frame.size() - 1);
			r.fill_level = wr_ptr - rd_ptr;
			r.empty_res = (wr_ptr == rd_ptr);
			expected_res.push_back(r);
		end
	endfunction

	task automatic check_result(input res_t got);
		res_t want;
		if (expected_res.size() == 0) begin
			note_failure($sformatf("result with nothing pending, byte %h", got.out_byte));
			return;
		end
		want = expected_res.pop_front();
		n_checked++;
		if (got.out_byte !== want.out_byte)
			note_failure($sformatf("out_byte %h, want %h", got.out_byte, want.out_byte));
		if (got.byte_valid !== want.byte_valid)
			note_failure($sformatf("byte_valid %b, want %b", got.byte_valid, want.byte_valid));
		if (got.last !== want.last)
			note_failure($sformatf("last %b, want %b", got.last, want.last));
		if (got.not_found !== want.not_found)
			note_failure($sformatf("not_found %b, want %b", got.not_found, want.not_found));
		if (got.overflow !== want.overflow)
			note_failure($sformatf("overflow %b, want %b", got.overflow, want.overflow));
		if (got.fill_level !== want.fill_level)
			note_failure($sformatf("fill_level %0d, want %0d", got.fill_level,
				want.fill_level));
		if (got.empty_res !== want.empty_res)
			note_failure($sformatf("empty_res %b, want %b", got.empty_res, want.empty_res));
	endtask

	function automatic int unsigned draw_idle(bit calm);
		return calm ? 0 : $urandom_range(0, 19);
	endfunction

	// random data byte, never the sentinel used to flush the ring
	function automatic logic [BYTE_W-1:0] rand_data();
		logic [BYTE_W-1:0] b;
		b = BYTE_W'($urandom_range(0, 255));
		while (b == SENTINEL)
			b = BYTE_W'($urandom_range(0, 255));
		return b;
	endfunction

	function automatic void add_push(logic [BYTE_W-1:0] b, bit drain = 1'b0);
		ring_req_t q;
		q.cmd = CMD_PUSH;
		q.push_byte = b;
		q.delimiter = BYTE_W'($urandom_range(0, 255));
		q.drain_first = drain;
		pending_reqs.push_back(q);
	endfunction

	function automatic void add_consume(logic [BYTE_W-1:0] d, bit drain = 1'b0);
		ring_req_t q;
		q.cmd = CMD_CONSUME;
		q.push_byte = BYTE_W'($urandom_range(0, 255));
		q.delimiter = d;
		q.drain_first = drain;
		pending_reqs.push_back(q);
	endfunction

	// short run of data bytes closed by a delimiter, then a consume of it
	function automatic void add_frame();
		int unsigned       n;
		logic [BYTE_W-1:0] d;
		n = $urandom_range(0, 6);
		repeat (n)
			add_push(rand_data());
		d = rand_data();
		add_push(d);
		add_consume(d);
	endfunction

	// request side: sample handshakes, predict on acceptance
	always @(posedge clk) begin
		req_fire <= arst_n && cmd_ch.valid && cmd_ch.ready;
		if (arst_n && cmd_ch.valid && cmd_ch.ready) begin
			n_accepted++;
			predict_request(cmd_ch.cmd, cmd_ch.push_byte, cmd_ch.delimiter);
		end
	end

	// result side: compare every accepted result
	always @(posedge clk) begin
		res_t got;
		res_fire <= arst_n && res_ch.valid && res_ch.ready;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			got.out_byte = res_ch.out_byte;
			got.byte_valid = res_ch.byte_valid;
			got.last = res_ch.last;
			got.not_found = res_ch.not_found;
			got.overflow = res_ch.overflow;
			got.fill_level = res_ch.fill_level;
			got.empty_res = res_ch.empty_res;
			check_result(got);
		end
	end

	// request driver
	bit          tx_busy = 1'b0;
	bit          tx_calm = 1'b0;
	int unsigned tx_gap = 0;

	always @(negedge clk) begin
		ring_req_t cur;
		if (!arst_n) begin
			cmd_ch.valid <= 1'b0;
		end else begin
			if (tx_busy && req_fire) begin
				tx_busy = 1'b0;
				if ($urandom_range(0, 15) == 0)
					tx_calm = !tx_calm;
				tx_gap = draw_idle(tx_calm);
			end
			if (!tx_busy) begin
				if (tx_gap > 0) begin
					tx_gap--;
				end else if (pending_reqs.size() > 0 &&
					!(pending_reqs[0].drain_first && expected_res.size() > 0)) begin
					cur = pending_reqs.pop_front();
					cmd_ch.cmd <= cur.cmd;
					cmd_ch.push_byte <= cur.push_byte;
					cmd_ch.delimiter <= cur.delimiter;
					tx_busy = 1'b1;
				end
			end
			cmd_ch.valid <= tx_busy;
		end
	end

	// result receiver: random stalls plus one long hold-off
	bit          rx_calm = 1'b0;
	int unsigned rx_pause = 0;
	int unsigned rx_hold = 0;
	int unsigned rx_count = 0;

	always @(negedge clk) begin
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
		end else begin
			if (res_fire) begin
				rx_count++;
				if ($urandom_range(0, 15) == 0)
					rx_calm = !rx_calm;
				rx_pause = draw_idle(rx_calm);
				if (rx_count == HOLD_AT)
					rx_hold = HOLD_LEN;
			end
			if (rx_hold > 0) begin
				rx_hold--;
				res_ch.ready <= 1'b0;
			end else if (rx_pause > 0) begin
				rx_pause--;
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= 1'b1;
			end
		end
	end

	// stimulus, reset and end of run
	initial begin
		cmd_ch.valid = 1'b0;
		cmd_ch.cmd = CMD_PUSH;
		cmd_ch.push_byte = '0;
		cmd_ch.delimiter = '0;
		res_ch.ready = 1'b0;

		// directed: empty ring, extremes, absent and repeated delimiters
		add_consume(8'h00);
		add_push(8'h00);
		add_push(8'hFF);
		add_push(8'h5A);
		add_consume(8'hA5);
		add_consume(8'hFF);
		add_consume(8'h5A);
		add_consume(8'h5A);
		add_push(8'hFF);
		add_push(8'h00);
		add_push(8'h00);
		add_consume(8'h00);
		add_consume(8'h00);
		add_push(8'h80);
		add_push(8'h01);
		add_consume(8'h80);
		add_consume(8'h01);

		// random mix, mostly well-formed frames
		pending_reqs[pending_reqs.size() - 1].drain_first = 1'b0;
		while (pending_reqs.size() < 40) begin
			case ($urandom_range(0, 9))
				0, 1: add_consume(rand_data());
				2, 3: add_push(rand_data());
				default: add_frame();
			endcase
		end

		// flush, fill to the brim, overflow, then pop one frame of the whole ring
		add_push(SENTINEL, 1'b1);
		add_consume(SENTINEL);
		repeat (62)
			add_push(rand_data());
		add_push(SENTINEL);
		repeat (3)
			add_push(rand_data());
		add_consume(rand_data());
		add_consume(SENTINEL);

		repeat (2)
			add_frame();

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (pending_reqs.size() > 0 || tx_busy || expected_res.size() > 0)
			@(posedge clk);
		repeat (TAIL_WAIT) @(posedge clk);

		foreach (expected_res[i])
			note_failure($sformatf("result never came, byte %h", expected_res[i].out_byte));
		$display("Run covered %0d requests and %0d results: %0d frames (longest %0d bytes),",
			n_accepted, n_checked, n_frames, max_frame);
		$display("%0d consumes without a delimiter, %0d pushes dropped on a full ring.",
			n_not_found, n_overflow);
		if (n_fail == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	initial begin
		#(TIMEOUT_NS);
		$display("Timeout with %0d results still pending", expected_res.size());
		$display("FAILED: results differ");
		$finish;
	end

endmodule
